### src/omni_mix_pkg.sv
`timescale 1ns / 1ps

package omni_mix_pkg;

   localparam int unsigned FIELD_W   = 16;
   localparam int unsigned LIM_W     = 15;
   localparam int unsigned NUM_WHEEL = 3;
   localparam int unsigned CSR_IDX_W = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRONT_DIR_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRONT_DIR_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_DIR_X    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_DIR_Y    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_DIR_X   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_DIR_Y   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTATION_LIM  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_LIM     = 3'd7;

   // wheel order in the per-wheel arrays
   localparam int unsigned WHEEL_FRONT = 0;
   localparam int unsigned WHEEL_LEFT  = 1;
   localparam int unsigned WHEEL_RIGHT = 2;

   localparam logic [FIELD_W-1:0] RST_FRONT_DIR_X = 16'h7FFF;
   localparam logic [FIELD_W-1:0] RST_FRONT_DIR_Y = 16'h0000;
   localparam logic [FIELD_W-1:0] RST_LEFT_DIR_X  = 16'hC000;
   localparam logic [FIELD_W-1:0] RST_LEFT_DIR_Y  = 16'h9126;
   localparam logic [FIELD_W-1:0] RST_RIGHT_DIR_X = 16'hC000;
   localparam logic [FIELD_W-1:0] RST_RIGHT_DIR_Y = 16'h6EDA;
   localparam logic [LIM_W-1:0]   RST_ROT_LIM     = 15'h4000;
   localparam logic [LIM_W-1:0]   RST_SPEED_LIM   = 15'h7FFF;

   typedef struct packed {
      logic signed [FIELD_W-1:0] front_speed;
      logic signed [FIELD_W-1:0] left_speed;
      logic signed [FIELD_W-1:0] right_speed;
      logic                      was_scaled;
   } result_type;

endpackage

### src/three_wheel_omni_drive_mixer.sv
`timescale 1ns / 1ps

// Three wheel omni drive mixer.
// Input channel req_*: one motion command (move_x, move_y, rotation, Q1.15)
// per item. Result channel rsp_*: three wheel speeds and was_scaled, exactly
// one result item per command, in order. Both channels are valid/ready.
// csr_*: write-only register port, csr_we with csr_index and csr_wdata;
// the user must write registers only while no item is in flight; the block does not enforce this.
// Throughput: one item per cycle while the output queue is not full. The
// pipeline holds the projection/rounding stages and the divider for the
// limit scaling, which resolves one quotient bit per stage (15 stages).
// The pipeline moves as a whole; a two-entry output queue sits between it and
// the result side, so req_ready depends only on that queue's fill and a
// result waiting in the queue does not stop new items entering.
// When the receiver stalls the queue fills and then the pipeline holds,
// losing nothing. Reset (synchronous, active high) empties the pipeline and
// queue and loads the default wheel directions and limits.
module three_wheel_omni_drive_mixer #(
   parameter int FRAC_BITS = 15
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [omni_mix_pkg::FIELD_W-1:0] req_move_x,
   input  logic signed [omni_mix_pkg::FIELD_W-1:0] req_move_y,
   input  logic signed [omni_mix_pkg::FIELD_W-1:0] req_rotation,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [omni_mix_pkg::FIELD_W-1:0] rsp_front_speed,
   output logic signed [omni_mix_pkg::FIELD_W-1:0] rsp_left_speed,
   output logic signed [omni_mix_pkg::FIELD_W-1:0] rsp_right_speed,
   output logic                                    rsp_was_scaled,
   input  logic                                    csr_we,
   input  logic [omni_mix_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [omni_mix_pkg::FIELD_W-1:0]        csr_wdata
);

   localparam int W      = omni_mix_pkg::FIELD_W;
   localparam int LW     = omni_mix_pkg::LIM_W;
   localparam int NW     = omni_mix_pkg::NUM_WHEEL;
   localparam int PROD_W = 2 * W;
   localparam int PSUM_W = PROD_W + 1;
   localparam int RND_W  = PROD_W - FRAC_BITS;
   localparam int SUM_W  = (((RND_W + 1) > (W + 1)) ? (RND_W + 1) : (W + 1)) + 1;
   localparam int MAG_W  = SUM_W - 1;
   localparam int NUM_W  = MAG_W + LW;
   localparam int QW     = LW;
   localparam int DIV0   = 7;
   localparam int NST    = DIV0 + QW + 1;
   localparam logic [PSUM_W-1:0] RND_HALF = {{(PSUM_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

   // ---------------- configuration registers
   logic signed [W-1:0]  dir_x_ff [NW];
   logic signed [W-1:0]  dir_y_ff [NW];
   logic signed [W-1:0]  dir_x_in [NW];
   logic signed [W-1:0]  dir_y_in [NW];
   logic [LW-1:0]        rot_lim_ff, rot_lim_in;
   logic [LW-1:0]        spd_lim_ff, spd_lim_in;

   always_comb begin
      dir_x_in   = dir_x_ff;
      dir_y_in   = dir_y_ff;
      rot_lim_in = rot_lim_ff;
      spd_lim_in = spd_lim_ff;
      if (csr_we) begin
         unique case (csr_index)
            omni_mix_pkg::CSR_FRONT_DIR_X:
               dir_x_in[omni_mix_pkg::WHEEL_FRONT] = $signed(csr_wdata);
            omni_mix_pkg::CSR_FRONT_DIR_Y:
               dir_y_in[omni_mix_pkg::WHEEL_FRONT] = $signed(csr_wdata);
            omni_mix_pkg::CSR_LEFT_DIR_X:
               dir_x_in[omni_mix_pkg::WHEEL_LEFT] = $signed(csr_wdata);
            omni_mix_pkg::CSR_LEFT_DIR_Y:
               dir_y_in[omni_mix_pkg::WHEEL_LEFT] = $signed(csr_wdata);
            omni_mix_pkg::CSR_RIGHT_DIR_X:
               dir_x_in[omni_mix_pkg::WHEEL_RIGHT] = $signed(csr_wdata);
            omni_mix_pkg::CSR_RIGHT_DIR_Y:
               dir_y_in[omni_mix_pkg::WHEEL_RIGHT] = $signed(csr_wdata);
            omni_mix_pkg::CSR_ROTATION_LIM: rot_lim_in = csr_wdata[LW-1:0];
            omni_mix_pkg::CSR_SPEED_LIM:    spd_lim_in = csr_wdata[LW-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_x_ff[omni_mix_pkg::WHEEL_FRONT] <= $signed(omni_mix_pkg::RST_FRONT_DIR_X);
         dir_y_ff[omni_mix_pkg::WHEEL_FRONT] <= $signed(omni_mix_pkg::RST_FRONT_DIR_Y);
         dir_x_ff[omni_mix_pkg::WHEEL_LEFT]  <= $signed(omni_mix_pkg::RST_LEFT_DIR_X);
         dir_y_ff[omni_mix_pkg::WHEEL_LEFT]  <= $signed(omni_mix_pkg::RST_LEFT_DIR_Y);
         dir_x_ff[omni_mix_pkg::WHEEL_RIGHT] <= $signed(omni_mix_pkg::RST_RIGHT_DIR_X);
         dir_y_ff[omni_mix_pkg::WHEEL_RIGHT] <= $signed(omni_mix_pkg::RST_RIGHT_DIR_Y);
         rot_lim_ff <= omni_mix_pkg::RST_ROT_LIM;
         spd_lim_ff <= omni_mix_pkg::RST_SPEED_LIM;
      end else begin
         dir_x_ff   <= dir_x_in;
         dir_y_ff   <= dir_y_in;
         rot_lim_ff <= rot_lim_in;
         spd_lim_ff <= spd_lim_in;
      end
   end

   // ---------------- pipeline control
   logic [NST-1:0] v_ff, v_in;
   logic           pipe_en;
   logic [1:0]     cnt_ff, cnt_in;

   assign pipe_en   = (cnt_ff != 2'd2);
   assign req_ready = pipe_en;
   assign v_in      = {v_ff[NST-2:0], req_valid};

   // ---------------- stage registers
   logic signed [W-1:0]      x_ff, x_in, y_ff, y_in, rot0_ff, rot0_in;
   logic signed [PROD_W-1:0] px_ff [NW];
   logic signed [PROD_W-1:0] px_in [NW];
   logic signed [PROD_W-1:0] py_ff [NW];
   logic signed [PROD_W-1:0] py_in [NW];
   logic signed [W-1:0]      rot1_ff, rot2_ff, rot3_ff;
   logic signed [PSUM_W-1:0] psum_ff [NW];
   logic signed [PSUM_W-1:0] psum_in [NW];
   logic [NW-1:0]            neg3_ff, neg3_in;
   logic [RND_W-1:0]         rnd_ff [NW];
   logic [RND_W-1:0]         rnd_in [NW];
   logic signed [SUM_W-1:0]  w_ff [NW];
   logic signed [SUM_W-1:0]  w_in [NW];
   logic [MAG_W-1:0]         mag_ff [NW];
   logic [MAG_W-1:0]         mag_in [NW];
   logic [NW-1:0]            sgn5_ff, sgn5_in, sgn6_ff;
   logic [W-1:0]             wl5_ff [NW];
   logic [W-1:0]             wl5_in [NW];
   logic [W-1:0]             wl6_ff [NW];
   logic [NUM_W-1:0]         num_ff [NW];
   logic [NUM_W-1:0]         num_in [NW];
   logic [MAG_W-1:0]         mx_ff, mx_in;

   // divider stages: index 0 takes the scale decision, then one quotient bit each
   logic [NUM_W-1:0] rem_ff [QW+1][NW];
   logic [NUM_W-1:0] rem_in [QW+1][NW];
   logic [LW-1:0]    quo_ff [QW+1][NW];
   logic [LW-1:0]    quo_in [QW+1][NW];
   logic [MAG_W-1:0] dmx_ff [QW+1];
   logic [MAG_W-1:0] dmx_in [QW+1];
   logic             dsc_ff [QW+1];
   logic             dsc_in [QW+1];
   logic [NW-1:0]    dsg_ff [QW+1];
   logic [NW-1:0]    dsg_in [QW+1];
   logic [W-1:0]     dwl_ff [QW+1][NW];
   logic [W-1:0]     dwl_in [QW+1][NW];

   // stage 0: capture, rotation clamp
   always_comb begin
      logic signed [W:0] rot_ext;
      logic signed [W:0] lim_ext;
      rot_ext = (W+1)'(req_rotation);
      lim_ext = $signed({2'b00, rot_lim_ff});
      x_in    = req_move_x;
      y_in    = req_move_y;
      priority if (rot_ext > lim_ext) rot0_in = W'(lim_ext);
      else if (rot_ext < -lim_ext)    rot0_in = W'(-lim_ext);
      else                            rot0_in = req_rotation;
   end

   // stages 1 to 6
   always_comb begin
      logic [PSUM_W-1:0] abs_p;
      logic [PSUM_W-1:0] rsum;
      logic signed [SUM_W-1:0] rext;
      logic [MAG_W-1:0] m01;
      for (int k = 0; k < NW; k++) begin
         px_in[k]   = PROD_W'(x_ff) * PROD_W'(dir_x_ff[k]);
         py_in[k]   = PROD_W'(y_ff) * PROD_W'(dir_y_ff[k]);
         psum_in[k] = PSUM_W'(px_ff[k]) + PSUM_W'(py_ff[k]);
         // round to nearest, ties away from zero, on the magnitude
         neg3_in[k] = psum_ff[k][PSUM_W-1];
         abs_p      = neg3_in[k] ? PSUM_W'(-psum_ff[k]) : PSUM_W'(psum_ff[k]);
         rsum       = abs_p + RND_HALF;
         rnd_in[k]  = RND_W'(rsum >> FRAC_BITS);
         rext       = $signed({{(SUM_W-RND_W){1'b0}}, rnd_ff[k]});
         w_in[k]    = neg3_ff[k] ? SUM_W'(rot3_ff) - rext : SUM_W'(rot3_ff) + rext;
         sgn5_in[k] = w_ff[k][SUM_W-1];
         mag_in[k]  = sgn5_in[k] ? MAG_W'(-w_ff[k]) : MAG_W'(w_ff[k]);
         wl5_in[k]  = w_ff[k][W-1:0];
         num_in[k]  = NUM_W'(mag_ff[k]) * NUM_W'(spd_lim_ff);
      end
      m01   = (mag_ff[0] > mag_ff[1]) ? mag_ff[0] : mag_ff[1];
      mx_in = (m01 > mag_ff[2]) ? m01 : mag_ff[2];
   end

   // divider: when scaling applies the quotient is at most the limit, so LW bits cover it
   always_comb begin
      logic [NUM_W-1:0] trial;
      rem_in[0] = num_ff;
      dmx_in[0] = mx_ff;
      dsc_in[0] = mx_ff > MAG_W'(spd_lim_ff);
      dsg_in[0] = sgn6_ff;
      dwl_in[0] = wl6_ff;
      for (int k = 0; k < NW; k++) quo_in[0][k] = '0;
      for (int s = 1; s <= QW; s++) begin
         dmx_in[s] = dmx_ff[s-1];
         dsc_in[s] = dsc_ff[s-1];
         dsg_in[s] = dsg_ff[s-1];
         dwl_in[s] = dwl_ff[s-1];
         trial     = NUM_W'(dmx_ff[s-1]) << (QW - s);
         for (int k = 0; k < NW; k++) begin
            if (rem_ff[s-1][k] >= trial) begin
               rem_in[s][k] = rem_ff[s-1][k] - trial;
               quo_in[s][k] = quo_ff[s-1][k] | (LW'(1) << (QW - s));
            end else begin
               rem_in[s][k] = rem_ff[s-1][k];
               quo_in[s][k] = quo_ff[s-1][k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (pipe_en) v_ff <= v_in;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         rot0_ff <= rot0_in;
         px_ff   <= px_in;
         py_ff   <= py_in;
         rot1_ff <= rot0_ff;
         psum_ff <= psum_in;
         rot2_ff <= rot1_ff;
         neg3_ff <= neg3_in;
         rnd_ff  <= rnd_in;
         rot3_ff <= rot2_ff;
         w_ff    <= w_in;
         mag_ff  <= mag_in;
         sgn5_ff <= sgn5_in;
         wl5_ff  <= wl5_in;
         num_ff  <= num_in;
         mx_ff   <= mx_in;
         sgn6_ff <= sgn5_ff;
         wl6_ff  <= wl5_ff;
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         dmx_ff  <= dmx_in;
         dsc_ff  <= dsc_in;
         dsg_ff  <= dsg_in;
         dwl_ff  <= dwl_in;
      end
   end

   // ---------------- result assembly
   omni_mix_pkg::result_type res;
   logic [W-1:0]             spd [NW];

   always_comb begin
      logic [W-1:0] q_ext;
      for (int k = 0; k < NW; k++) begin
         q_ext = W'(quo_ff[QW][k]);
         if (dsc_ff[QW]) spd[k] = dsg_ff[QW][k] ? -q_ext : q_ext;
         else            spd[k] = dwl_ff[QW][k];
      end
      res.front_speed = $signed(spd[omni_mix_pkg::WHEEL_FRONT]);
      res.left_speed  = $signed(spd[omni_mix_pkg::WHEEL_LEFT]);
      res.right_speed = $signed(spd[omni_mix_pkg::WHEEL_RIGHT]);
      res.was_scaled  = dsc_ff[QW];
   end

   // ---------------- output queue, two items
   omni_mix_pkg::result_type fifo_ff [2];
   omni_mix_pkg::result_type fifo_in [2];
   logic wp_ff, wp_in, rp_ff, rp_in;
   logic push, pop;

   assign push = pipe_en && v_ff[NST-1];
   assign pop  = rsp_valid && rsp_ready;

   always_comb begin
      fifo_in = fifo_ff;
      if (push) fifo_in[wp_ff] = res;
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      fifo_ff <= fifo_in;
   end

   assign rsp_valid       = (cnt_ff != 2'd0);
   assign rsp_front_speed = fifo_ff[rp_ff].front_speed;
   assign rsp_left_speed  = fifo_ff[rp_ff].left_speed;
   assign rsp_right_speed = fifo_ff[rp_ff].right_speed;
   assign rsp_was_scaled  = fifo_ff[rp_ff].was_scaled;

`ifndef NO_ASSERTIONS
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v_ff[0])
      else $error("accepted item did not enter the pipeline");

   a_front_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((W+1)'(rsp_front_speed) <= $signed({2'b00, spd_lim_ff}) &&
                     (W+1)'(rsp_front_speed) >= -$signed({2'b00, spd_lim_ff})))
      else $error("front speed beyond speed limit");

   a_left_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((W+1)'(rsp_left_speed) <= $signed({2'b00, spd_lim_ff}) &&
                     (W+1)'(rsp_left_speed) >= -$signed({2'b00, spd_lim_ff})))
      else $error("left speed beyond speed limit");

   a_right_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((W+1)'(rsp_right_speed) <= $signed({2'b00, spd_lim_ff}) &&
                     (W+1)'(rsp_right_speed) >= -$signed({2'b00, spd_lim_ff})))
      else $error("right speed beyond speed limit");
`endif

endmodule
